// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the GC content counter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gcc_pkg.sv =====
// Shared defaults and output layout constants for the GC content counter.
package gcc_pkg;

    localparam int COUNT_BITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 16;

    // Output field widths, fixed by the result item format.
    localparam int FIELD_W = 32;
    localparam int FRAC_W  = 17;

    // Packed result data: 258 bits of fields padded to 33 bytes.
    localparam int M_TDATA_W = 264;
    localparam int M_PAD_W   = M_TDATA_W - (7 * FIELD_W) - (2 * FRAC_W);

endpackage

// ===== rtl/gcc_parser.sv =====
// FASTA byte parser with saturating record and genome counters.
module gcc_parser
    import gcc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_accept,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    output logic                  close_o,
    output logic [COUNT_BITS-1:0] snap_num,
    output logic [COUNT_BITS-1:0] snap_gc,
    output logic [COUNT_BITS-1:0] snap_len,
    output logic [COUNT_BITS-1:0] snap_a,
    output logic [COUNT_BITS-1:0] snap_t,
    output logic [COUNT_BITS-1:0] snap_g,
    output logic [COUNT_BITS-1:0] snap_c,
    output logic                  snap_last
);

    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_G    = 8'h47;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CASE_MASK = 8'hDF;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        M_FIRST  = 3'b001,
        M_HEADER = 3'b010,
        M_SEQ    = 3'b100
    } mode_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    mode_t                 mode_reg, mode_next;
    logic [COUNT_BITS-1:0] gc_reg, len_reg, num_reg, a_reg, t_reg, g_reg, c_reg;
    logic [COUNT_BITS-1:0] gc_upd, len_upd, a_upd, t_upd, g_upd, c_upd;
    logic                  in_seq, is_gt, is_nl, count_byte;
    logic [7:0]            folded;

    assign in_seq     = (mode_reg == M_SEQ);
    assign is_gt      = (in_byte == CH_GT);
    assign is_nl      = (in_byte == CH_NL);
    assign count_byte = in_seq && !is_gt && !is_nl;
    assign folded     = in_byte & CASE_MASK;

    assign len_upd = count_byte ? sat_inc(len_reg) : len_reg;
    assign a_upd   = (count_byte && folded == CH_A) ? sat_inc(a_reg) : a_reg;
    assign t_upd   = (count_byte && folded == CH_T) ? sat_inc(t_reg) : t_reg;
    assign g_upd   = (count_byte && folded == CH_G) ? sat_inc(g_reg) : g_reg;
    assign c_upd   = (count_byte && folded == CH_C) ? sat_inc(c_reg) : c_reg;
    assign gc_upd  = (count_byte && (folded == CH_G || folded == CH_C)) ?
                     sat_inc(gc_reg) : gc_reg;

    assign close_o = in_accept && ((in_seq && is_gt) || in_last);

    always_comb begin
        case (mode_reg)
            M_FIRST:  mode_next = M_HEADER;
            M_HEADER: mode_next = is_nl ? M_SEQ : M_HEADER;
            M_SEQ:    mode_next = M_SEQ;
            default:  mode_next = M_FIRST;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_FIRST;
            gc_reg   <= '0;
            len_reg  <= '0;
            num_reg  <= '0;
            a_reg    <= '0;
            t_reg    <= '0;
            g_reg    <= '0;
            c_reg    <= '0;
        end else if (in_accept) begin
            if (close_o && in_last) begin
                mode_reg <= M_FIRST;
                gc_reg   <= '0;
                len_reg  <= '0;
                num_reg  <= '0;
                a_reg    <= '0;
                t_reg    <= '0;
                g_reg    <= '0;
                c_reg    <= '0;
            end else if (close_o) begin
                // A '>' closes the record and opens a new header line.
                mode_reg <= M_HEADER;
                gc_reg   <= '0;
                len_reg  <= '0;
                num_reg  <= sat_inc(num_reg);
            end else begin
                mode_reg <= mode_next;
                gc_reg   <= gc_upd;
                len_reg  <= len_upd;
                a_reg    <= a_upd;
                t_reg    <= t_upd;
                g_reg    <= g_upd;
                c_reg    <= c_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (close_o) begin
            snap_num  <= num_reg;
            snap_gc   <= gc_upd;
            snap_len  <= len_upd;
            snap_a    <= a_upd;
            snap_t    <= t_upd;
            snap_g    <= g_upd;
            snap_c    <= c_upd;
            snap_last <= in_last;
        end
    end

endmodule

// ===== rtl/gcc_divider.sv =====
// Shared restoring divider: floor(num * 2^FRACTION_BITS / den), at most 2^FRACTION_BITS, and 0 for den 0.
module gcc_divider
    import gcc_pkg::*;
#(
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [COUNT_BITS+1:0]    num,
    input  logic [COUNT_BITS+1:0]    den,
    output logic                     done,
    output logic [FRACTION_BITS:0]   quot
);

    `include "assert_macros.svh"

    localparam int N_W   = COUNT_BITS + 2;
    localparam int CNT_W = $clog2(FRACTION_BITS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FRACTION_BITS - 1);
    localparam logic [FRACTION_BITS:0] Q_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

    logic                   busy_reg, done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [N_W-1:0]         rem_reg, den_reg;
    logic [FRACTION_BITS:0] quot_reg;
    logic [N_W:0]           rem_sh, rem_sub;
    logic                   take;

    // One quotient bit per cycle: shift the remainder and try a subtract.
    assign rem_sh  = {rem_reg, 1'b0};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign take    = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            cnt_reg <= '0;
            if (den == '0 || num >= den) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
            end
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                done_reg <= 1'b0;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= num;
            if (den == '0) begin
                quot_reg <= '0;
            end else if (num >= den) begin
                quot_reg <= Q_ONE;
            end else begin
                quot_reg <= '0;
            end
        end else if (busy_reg) begin
            rem_reg  <= take ? rem_sub[N_W-1:0] : rem_sh[N_W-1:0];
            quot_reg <= {quot_reg[FRACTION_BITS-1:0], take};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

    `ASSERT_NEXT(a_start_runs, aclk, aresetn, start, busy_reg || done_reg, "start ignored")
    `ASSERT_IMPLIES(a_busy_not_done, aclk, aresetn, busy_reg, !done_reg, "busy and done")
    `ASSERT_NEXT(a_done_pulse, aclk, aresetn, done_reg, !done_reg, "done held")

endmodule

// ===== rtl/fasta_gc_content_counter.sv =====
// Top level of the FASTA GC content counter: sequencer, shared divider and result register.
//
// The s_ channel takes one byte of a FASTA file per item: s_tdata[7:0] is the byte and
// s_tlast marks the last byte of the file. The first byte and the rest of that header
// line are skipped; in sequence lines every byte except a newline counts toward the record
// length, and A, T, G and C in either case also count as bases. A '>' in a sequence line
// or the last byte closes the record and produces one item on the m_ channel.
// Ordinary bytes are taken at one per cycle. A closing byte drops s_tready while the shared
// divider computes the record GC fraction, one quotient bit per cycle, and at end of input
// also the genome fraction on the same divider. Degenerate divisions finish at once.
// After the last division the result waits in a hold state until the output register is
// free, then is loaded there and raises m_tvalid. It sits in that output register,
// so bytes keep flowing while the receiver stalls; only a second closing byte then waits,
// holding its finished result until m_tready frees the register.
// All counters return to their reset values when the last byte is taken, and after the
// final result (m_tlast high) the next byte starts a new file. A synchronous low aresetn
// clears the parser, the sequencer and the output valid at the next rising edge of aclk.
module fasta_gc_content_counter
    import gcc_pkg::*;
#(
    parameter int COUNT_BITS    = COUNT_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 s_tlast,   // end_of_input
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] record_number, [63:32] gc_bases, [95:64] record_bytes,
    // [112:96] gc_fraction, [144:113] genome_a, [176:145] genome_t,
    // [208:177] genome_g, [240:209] genome_c, [257:241] genome_gc_fraction,
    // [263:258] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,   // empty_record
    output logic                 m_tlast    // is_final
);

    `include "assert_macros.svh"

    localparam int N_W = COUNT_BITS + 2;

    // Sequencer: take bytes, divide for the record, at end of input divide for the genome, hand off.
    typedef enum logic [3:0] {
        ST_RUN  = 4'b0001,
        ST_DREC = 4'b0010,
        ST_DGEN = 4'b0100,
        ST_HOLD = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic                  launch_reg, launch_next;
    logic                  close;
    logic                  in_accept;
    logic                  in_div;
    logic [COUNT_BITS-1:0] snap_num, snap_gc, snap_len;
    logic [COUNT_BITS-1:0] snap_a, snap_t, snap_g, snap_c;
    logic                  snap_last;
    logic [N_W-1:0]        gnum_reg, gden_reg;
    logic [N_W-1:0]        div_num, div_den;
    logic                  div_done;
    logic [FRACTION_BITS:0] div_quot;
    logic [FRACTION_BITS:0] rec_frac_reg, gen_frac_reg;
    logic                  out_free, out_load;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic                  m_tuser_reg, m_tlast_reg;
    logic [FIELD_W-1:0]    ga_f, gt_f, gg_f, gc_f;
    logic [FRAC_W-1:0]     gfrac_f;

    assign s_tready  = (state_reg == ST_RUN);
    assign in_accept = s_tvalid && s_tready;
    assign in_div    = (state_reg == ST_DREC) || (state_reg == ST_DGEN);

    gcc_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .close_o   (close),
        .snap_num  (snap_num),
        .snap_gc   (snap_gc),
        .snap_len  (snap_len),
        .snap_a    (snap_a),
        .snap_t    (snap_t),
        .snap_g    (snap_g),
        .snap_c    (snap_c),
        .snap_last (snap_last)
    );

    // Genome sums are ready long before the genome division starts.
    always_ff @(posedge aclk) begin
        gnum_reg <= N_W'(snap_g) + N_W'(snap_c);
        gden_reg <= N_W'(snap_g) + N_W'(snap_c) + N_W'(snap_a) + N_W'(snap_t);
    end

    assign div_num = (state_reg == ST_DGEN) ? gnum_reg : N_W'(snap_gc);
    assign div_den = (state_reg == ST_DGEN) ? gden_reg : N_W'(snap_len);

    gcc_divider #(
        .COUNT_BITS    (COUNT_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (launch_reg),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_HOLD) && out_free;

    always_comb begin
        state_next  = state_reg;
        launch_next = 1'b0;
        case (state_reg)
            ST_RUN: begin
                if (close) begin
                    state_next  = ST_DREC;
                    launch_next = 1'b1;
                end
            end
            ST_DREC: begin
                if (div_done) begin
                    if (snap_last) begin
                        state_next  = ST_DGEN;
                        launch_next = 1'b1;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_DGEN: begin
                if (div_done) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_RUN;
            launch_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DREC && div_done) begin
            rec_frac_reg <= div_quot;
        end
        if (state_reg == ST_DGEN && div_done) begin
            gen_frac_reg <= div_quot;
        end
    end

    // Genome fields are zero on every result except the final one.
    assign ga_f    = snap_last ? FIELD_W'(snap_a) : '0;
    assign gt_f    = snap_last ? FIELD_W'(snap_t) : '0;
    assign gg_f    = snap_last ? FIELD_W'(snap_g) : '0;
    assign gc_f    = snap_last ? FIELD_W'(snap_c) : '0;
    assign gfrac_f = snap_last ? FRAC_W'(gen_frac_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, gfrac_f, gc_f, gg_f, gt_f, ga_f,
                            FRAC_W'(rec_frac_reg), FIELD_W'(snap_len),
                            FIELD_W'(snap_gc), FIELD_W'(snap_num)};
            m_tuser_reg <= (snap_len == '0);
            m_tlast_reg <= snap_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `ASSERT_IMPLIES(a_done_in_div, aclk, aresetn, div_done, in_div, "done outside a division")
    `ASSERT_NEXT(a_close_launch, aclk, aresetn, close, launch_reg && in_div, "no launch on close")
    `ASSERT_NEXT(a_hold_load, aclk, aresetn, out_load, m_tvalid_reg && s_tready, "lost result")

endmodule
